>>> rtl/dscs_pkg.sv
// ----------------------------------------------------------------------------
// dscs_pkg: shared definitions for the delayed sparse coupling sum
// Sizes, field widths, item kinds and the record types that pass between
// the front end, the command queue and the compute engine.
// ----------------------------------------------------------------------------
package dscs_pkg;

  // Network size and table sizes.
  localparam int NUM_NODES       = 64;
  localparam int HIST_AW         = 8;
  localparam int HISTORY_DEPTH   = 1 << HIST_AW;
  localparam int MAX_CONNECTIONS = 1024;

  localparam int NODE_AW   = $clog2(NUM_NODES);
  localparam int HIST_WA   = NODE_AW + HIST_AW;
  localparam int HIST_WORDS = NUM_NODES * HISTORY_DEPTH;
  localparam int CONN_AW   = $clog2(MAX_CONNECTIONS);
  localparam int CONN_CW   = $clog2(MAX_CONNECTIONS + 1);
  localparam int ROW_DEPTH = NUM_NODES + 1;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);

  // Fixed field widths of the stream items.
  localparam int KIND_W   = 2;
  localparam int NODE_W   = 7;
  localparam int SLOT_W   = 8;
  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = 11;
  localparam int SRC_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int DELAY_W  = 8;
  localparam int RNODE_W  = 6;
  localparam int SUM_W    = 48;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_CONN    = 2'd1,
    KIND_ROW     = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_t;

  // One connection table entry as stored in memory.
  typedef struct packed {
    logic [DELAY_W-1:0]  delay;
    logic [WEIGHT_W-1:0] weight;
    logic [SRC_W-1:0]    source;
  } conn_t;

  localparam int CONN_DW = $bits(conn_t);

  // A compute command waiting for the engine.
  typedef struct packed {
    logic [NODE_AW-1:0] node;
    logic [HIST_AW-1:0] now;
  } cmd_t;

  // Memory write requests issued by the front end.
  typedef struct packed {
    logic                hist_we;
    logic [HIST_WA-1:0]  hist_addr;
    logic [SAMPLE_W-1:0] hist_data;
    logic                conn_we;
    logic [CONN_AW-1:0]  conn_addr;
    conn_t               conn_data;
    logic                row_we;
    logic [ROW_AW-1:0]   row_addr;
    logic [ENTRY_W-1:0]  row_data;
  } wr_t;

  // Row bounds saturate at the table size.
  function automatic logic [CONN_CW-1:0] clamp_conn(input logic [ENTRY_W-1:0] v);
    if (v > ENTRY_W'(MAX_CONNECTIONS)) begin
      return CONN_CW'(MAX_CONNECTIONS);
    end
    return CONN_CW'(v);
  endfunction

endpackage

>>> rtl/dscs_ram.sv
// ----------------------------------------------------------------------------
// dscs_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dscs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dscs_front.sv
// ----------------------------------------------------------------------------
// dscs_front: input side of the coupling sum
// Accepts items, performs load writes and forwards compute commands.
// ----------------------------------------------------------------------------
module dscs_front
  import dscs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,
  input  logic [KIND_W-1:0]      s_tuser,
  input  logic                   q_full,
  input  logic                   q_empty,
  input  logic                   back_idle,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  output wr_t                    wr,
  output logic [ROW_DEPTH-1:0]   row_valid
);

  logic [NODE_W-1:0]   f_node;
  logic [SLOT_W-1:0]   f_slot;
  logic [SAMPLE_W-1:0] f_sample;
  logic [ENTRY_W-1:0]  f_entry;
  logic [SRC_W-1:0]    f_src;
  logic [WEIGHT_W-1:0] f_weight;
  logic [DELAY_W-1:0]  f_delay;
  logic                accept;
  logic                is_load;

  assign f_node   = s_tdata[6:0];
  assign f_slot   = s_tdata[14:7];
  assign f_sample = s_tdata[30:15];
  assign f_entry  = s_tdata[41:31];
  assign f_src    = s_tdata[47:42];
  assign f_weight = s_tdata[63:48];
  assign f_delay  = s_tdata[71:64];

  // Loads wait until every earlier compute has read the stores.
  assign is_load  = (s_tuser != KIND_COMPUTE);
  assign s_tready = is_load ? (q_empty && back_idle) : !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    wr = '0;
    wr.hist_we   = accept && (s_tuser == KIND_SAMPLE) && (f_node < NODE_W'(NUM_NODES))
                   && ({1'b0, f_slot} < (SLOT_W + 1)'(HISTORY_DEPTH));
    wr.hist_addr = {f_node[NODE_AW-1:0], f_slot[HIST_AW-1:0]};
    wr.hist_data = f_sample;
    wr.conn_we   = accept && (s_tuser == KIND_CONN)
                   && ({1'b0, f_entry} < (ENTRY_W + 1)'(MAX_CONNECTIONS));
    wr.conn_addr = f_entry[CONN_AW-1:0];
    wr.conn_data = '{delay: f_delay, weight: f_weight, source: f_src};
    wr.row_we    = accept && (s_tuser == KIND_ROW) && (f_node <= NODE_W'(NUM_NODES));
    wr.row_addr  = f_node[ROW_AW-1:0];
    wr.row_data  = f_entry;
  end

  assign q_push = accept && (s_tuser == KIND_COMPUTE) && (f_node < NODE_W'(NUM_NODES));
  assign q_cmd  = '{node: f_node[NODE_AW-1:0], now: f_slot[HIST_AW-1:0]};

  // A row start that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.row_we) begin
      row_valid[wr.row_addr] <= 1'b1;
    end
  end

endmodule

>>> rtl/dscs_queue.sv
// ----------------------------------------------------------------------------
// dscs_queue: two-entry command queue
// Holds compute commands between the front end and the compute engine.
// ----------------------------------------------------------------------------
module dscs_queue
  import dscs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/dscs_back.sv
// ----------------------------------------------------------------------------
// dscs_back: compute engine
// Walks one row of the connection table per command, one entry a cycle,
// and holds the finished sums in an output register.
// ----------------------------------------------------------------------------
module dscs_back
  import dscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  cmd_t                  q_head,
  output logic                  q_pop,
  output logic                  idle,
  input  logic [ROW_DEPTH-1:0]  row_valid,
  output logic [ROW_AW-1:0]     row_addr_a,
  output logic [ROW_AW-1:0]     row_addr_b,
  input  logic [ENTRY_W-1:0]    row_data_a,
  input  logic [ENTRY_W-1:0]    row_data_b,
  output logic [CONN_AW-1:0]    conn_raddr,
  input  conn_t                 conn_rdata,
  output logic [HIST_WA-1:0]    hist_raddr_a,
  output logic [HIST_WA-1:0]    hist_raddr_b,
  input  logic [SAMPLE_W-1:0]   hist_rdata_a,
  input  logic [SAMPLE_W-1:0]   hist_rdata_b,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic [1:0] {IDLE, BOUNDS, WALK, FIN} state_t;

  state_t                     state;
  logic [NODE_AW-1:0]         cur_node;
  logic [ROW_AW-1:0]          node_p1;
  logic [HIST_AW-1:0]         now;
  logic [CONN_CW-1:0]         ptr;
  logic [CONN_CW-1:0]         end_ptr;
  logic                       s1_v;
  logic                       s2_v;
  logic                       s3_v;
  logic [WEIGHT_W-1:0]        s2_w;
  logic signed [PROD_W-1:0]   prod_a;
  logic signed [PROD_W-1:0]   prod_b;
  logic signed [SUM_W-1:0]    acc_a;
  logic signed [SUM_W-1:0]    acc_b;
  logic [HIST_AW-1:0]         p_now;
  logic                       issue;
  logic [CONN_CW-1:0]         lo;
  logic [CONN_CW-1:0]         hi;

  assign idle       = (state == IDLE);
  assign q_pop      = idle && !q_empty;
  assign row_addr_a = ROW_AW'(q_head.node);
  assign row_addr_b = ROW_AW'(q_head.node) + ROW_AW'(1);
  assign issue      = (state == WALK) && (ptr < end_ptr);
  assign conn_raddr = ptr[CONN_AW-1:0];

  // Delay wraps around the power-of-two history ring.
  assign p_now        = now - conn_rdata.delay[HIST_AW-1:0];
  assign hist_raddr_a = {conn_rdata.source[NODE_AW-1:0], p_now};
  assign hist_raddr_b = {conn_rdata.source[NODE_AW-1:0], p_now + HIST_AW'(1)};

  assign lo = row_valid[ROW_AW'(cur_node)] ? clamp_conn(row_data_a) : '0;
  assign hi = row_valid[node_p1] ? clamp_conn(row_data_b) : '0;

  always_ff @(posedge clk) begin
    s2_w   <= conn_rdata.weight;
    prod_a <= $signed(s2_w) * $signed(hist_rdata_a);
    prod_b <= $signed(s2_w) * $signed(hist_rdata_b);
    if (rst) begin
      state    <= IDLE;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v && ({1'b0, conn_rdata.source} < (SRC_W + 1)'(NUM_NODES));
      s3_v <= s2_v;
      if (s3_v) begin
        acc_a <= acc_a + SUM_W'(prod_a);
        acc_b <= acc_b + SUM_W'(prod_b);
      end
      if (m_tvalid && m_tready && (state != FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (!q_empty) begin
            cur_node <= q_head.node;
            node_p1  <= ROW_AW'(q_head.node) + ROW_AW'(1);
            now      <= q_head.now;
            state    <= BOUNDS;
          end
        end
        BOUNDS: begin
          ptr     <= lo;
          end_ptr <= hi;
          acc_a   <= '0;
          acc_b   <= '0;
          state   <= WALK;
        end
        WALK: begin
          if (issue) begin
            ptr <= ptr + CONN_CW'(1);
          end else if (!s1_v && !s2_v && !s3_v) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, acc_b, acc_a, RNODE_W'(cur_node)};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> rtl/delayed_sparse_coupling_sum.sv
// ----------------------------------------------------------------------------
// delayed_sparse_coupling_sum: delayed sparse coupling for a node network
// Top level: front end, command queue, compute engine and storage.
// ----------------------------------------------------------------------------
// Load items (history sample, connection entry, row start) give no result.
// A compute item walks its node's row in the compressed-sparse-row table
// at one connection entry per cycle through the single connection-table
// read port and the three-stage read, multiply and accumulate pipe. Up
// to two compute items wait in the queue while the engine works, but a
// load item is held off until every earlier compute has finished reading
// the stores, so results always match the stores as they stood when the
// compute item was accepted. The finished sums sit in an output register,
// and the engine starts the next queued compute while that register waits
// to be taken. History and connection entries that were never written
// read as arbitrary values; row starts read as zero until written.
// ----------------------------------------------------------------------------
module delayed_sparse_coupling_sum
  import dscs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // node[6:0], slot[14:7], sample[30:15], entry[41:31],
  // source_node[47:42], weight[63:48], delay[71:64]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // result_node[5:0], coupling_now[53:6], coupling_next[101:54], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  wr_t                  wr;
  logic [ROW_DEPTH-1:0] row_valid;
  logic                 q_push;
  logic                 q_pop;
  cmd_t                 q_cmd;
  cmd_t                 q_head;
  logic                 q_empty;
  logic                 q_full;
  logic                 back_idle;
  logic [ROW_AW-1:0]    row_addr_a;
  logic [ROW_AW-1:0]    row_addr_b;
  logic [ENTRY_W-1:0]   row_data_a;
  logic [ENTRY_W-1:0]   row_data_b;
  logic [CONN_AW-1:0]   conn_raddr;
  conn_t                conn_rdata;
  logic [HIST_WA-1:0]   hist_raddr_a;
  logic [HIST_WA-1:0]   hist_raddr_b;
  logic [SAMPLE_W-1:0]  hist_rdata_a;
  logic [SAMPLE_W-1:0]  hist_rdata_b;

  dscs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .back_idle (back_idle),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .wr        (wr),
    .row_valid (row_valid)
  );

  dscs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The history is kept twice so that both slots of a connection are read
  // in the same cycle.
  dscs_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_WORDS)) u_hist_a (
    .clk (clk), .we (wr.hist_we), .waddr (wr.hist_addr), .wdata (wr.hist_data),
    .raddr (hist_raddr_a), .rdata (hist_rdata_a)
  );

  dscs_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_WORDS)) u_hist_b (
    .clk (clk), .we (wr.hist_we), .waddr (wr.hist_addr), .wdata (wr.hist_data),
    .raddr (hist_raddr_b), .rdata (hist_rdata_b)
  );

  dscs_ram #(.WIDTH(CONN_DW), .DEPTH(MAX_CONNECTIONS)) u_conn (
    .clk (clk), .we (wr.conn_we), .waddr (wr.conn_addr), .wdata (wr.conn_data),
    .raddr (conn_raddr), .rdata (conn_rdata)
  );

  // Row starts are also duplicated: one copy gives the row start, the
  // other the start of the following row.
  dscs_ram #(.WIDTH(ENTRY_W), .DEPTH(ROW_DEPTH)) u_row_a (
    .clk (clk), .we (wr.row_we), .waddr (wr.row_addr), .wdata (wr.row_data),
    .raddr (row_addr_a), .rdata (row_data_a)
  );

  dscs_ram #(.WIDTH(ENTRY_W), .DEPTH(ROW_DEPTH)) u_row_b (
    .clk (clk), .we (wr.row_we), .waddr (wr.row_addr), .wdata (wr.row_data),
    .raddr (row_addr_b), .rdata (row_data_b)
  );

  dscs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .idle         (back_idle),
    .row_valid    (row_valid),
    .row_addr_a   (row_addr_a),
    .row_addr_b   (row_addr_b),
    .row_data_a   (row_data_a),
    .row_data_b   (row_data_b),
    .conn_raddr   (conn_raddr),
    .conn_rdata   (conn_rdata),
    .hist_raddr_a (hist_raddr_a),
    .hist_raddr_b (hist_raddr_b),
    .hist_rdata_a (hist_rdata_a),
    .hist_rdata_b (hist_rdata_b),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

endmodule

>>> rtl/dscs_checker.sv
// ----------------------------------------------------------------------------
// dscs_checker: port-level checks for the coupling sum
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module dscs_checker
  import dscs_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic [KIND_W-1:0]     s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // The padding above the second sum is always zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:102] == '0)
    else $error("result padding not zero");

  // A load is never taken in the cycle right after a compute for a node in range was taken.
  a_order: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == KIND_COMPUTE && s_tdata[6:0] < 7'd64
    |=> !(s_tvalid && s_tready && s_tuser != KIND_COMPUTE))
    else $error("load taken while a compute was pending");

endmodule

bind delayed_sparse_coupling_sum dscs_checker u_dscs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
